FILE: src/psrat_pkg.sv
`default_nettype none

package psrat_pkg;

    // Table geometry.
    localparam int NUM_SOURCES = 16;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    // Field widths.
    localparam int ID_W    = 8;
    localparam int RSSI_W  = 8;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 24;
    localparam int DMG_W   = 16;

    // Stream widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Count limits.
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] MIN_PACKETS = COUNT_W'(3);

    // Window compare against the table size, one bit wider than an id.
    localparam logic [ID_W:0] NUM_SOURCES_EXT = (ID_W + 1)'(NUM_SOURCES);

    // Divider: one quotient bit per step over the whole sum magnitude.
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SOURCE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SOURCE_ID  = 1'b1;

    // Request kinds carried in tuser.
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_EXEC,
        ST_DIV,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: src/per_source_rssi_average_threshold.sv
// Flow: a request passes through ST_MAP and ST_EXEC to ST_DONE; a check of an entry with three
// or more packets also passes through ST_DIV and ST_FINISH, where the serial divider runs.
// Throughput: one request at a time; the next is taken once the result has moved into the
// output register.
// Reset: synchronous, active low; clears the table and all handshakes, and sets the window to sources 0 to 15.
`default_nettype none

module per_source_rssi_average_threshold
    import psrat_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Request stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: source_id[7:0], rssi[15:8], rssi_threshold[23:16], damage_value[39:24]
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: action (0 = packet received, 1 = check and clear)
    input  wire logic                  i_s_tuser,

    // Result stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: in_table[0], near[1], average_rssi[9:2], damage[25:10], zero[31:26]
    output logic [M_TDATA_W-1:0]       o_m_tdata,

    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ID_W-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // State and registers.
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // Window configuration.
    logic [ID_W-1:0] r_first;
    logic [ID_W-1:0] r_last;

    // Captured request.
    logic                     r_action;
    logic [ID_W-1:0]          r_src;
    logic signed [RSSI_W-1:0] r_rssi;
    logic signed [RSSI_W-1:0] r_thr_in;
    logic [DMG_W-1:0]         r_dmg_in;

    // Table lookup result.
    logic             r_hit;
    logic [IDX_W-1:0] r_idx;

    // Beacon table, one entry for each of the first NUM_SOURCES sources of the window.
    logic [COUNT_W-1:0]       r_count [NUM_SOURCES];
    logic signed [SUM_W-1:0]  r_sum   [NUM_SOURCES];
    logic signed [RSSI_W-1:0] r_thr   [NUM_SOURCES];
    logic [DMG_W-1:0]         r_dmg   [NUM_SOURCES];

    // Serial divider: the quotient shifts in as the dividend shifts out.
    logic [SUM_W-1:0]   r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_neg;

    // Result staging, filled before the output register takes it.
    logic                     r_res_in_table;
    logic                     r_res_near;
    logic [RSSI_W-1:0]        r_res_avg;
    logic [DMG_W-1:0]         r_res_dmg;

    // Output register.
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    // Handshake strobes from the output decode.
    logic w_in_ready;
    logic w_out_load;

    // ------------------------------------------------------------------
    // Window mapping. The offset is one bit wider than an id so that a
    // table of 256 entries still compares correctly.
    // ------------------------------------------------------------------
    logic [ID_W:0] w_off;
    logic          w_hit;

    assign w_off = {1'b0, r_src} - {1'b0, r_first};
    assign w_hit = (r_src >= r_first) && (r_src <= r_last) && (w_off < NUM_SOURCES_EXT);

    // Entry fields at the current index.
    logic [COUNT_W-1:0]       w_cnt;
    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]         w_sum_mag;
    logic                     w_sat;
    logic                     w_few;

    assign w_cnt     = r_count[r_idx];
    assign w_sum     = r_sum[r_idx];
    // The sum never reaches the most negative 24-bit value, so negation is safe.
    assign w_sum_mag = w_sum[SUM_W-1] ? (SUM_W'(0) - w_sum) : w_sum;
    assign w_sat     = (w_cnt == COUNT_MAX);
    assign w_few     = (w_cnt < MIN_PACKETS);

    // ------------------------------------------------------------------
    // Divider step: restoring division, one quotient bit per cycle.
    // ------------------------------------------------------------------
    logic [COUNT_W:0] w_shift;
    logic             w_ge;
    logic [COUNT_W:0] w_diff;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    // ------------------------------------------------------------------
    // Finishing: the quotient magnitude is at most 128, so nine bits carry
    // the signed average before it is cut to eight.
    // ------------------------------------------------------------------
    logic [RSSI_W:0]        w_qmag;
    logic signed [RSSI_W:0] w_avg;
    logic signed [RSSI_W:0] w_thr_ext;

    assign w_qmag    = r_quo[RSSI_W:0];
    assign w_avg     = r_neg ? ((RSSI_W + 1)'(0) - w_qmag) : w_qmag;
    assign w_thr_ext = {r_thr[r_idx][RSSI_W-1], r_thr[r_idx]};

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                // Only a check of a mapped entry with enough packets divides.
                if (r_hit && (r_action == ACT_CHECK) && !w_few) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_dcnt == DIV_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: handshake decode.
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_DONE: begin
                // The result moves on once the output register is free or drains now.
                w_out_load = !r_m_tvalid || i_m_tready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers. The channel never stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_last  <= ID_W'(15);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_SOURCE_ID: r_first <= i_cfg_data;
                CFG_LAST_SOURCE_ID:  r_last  <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request capture and lookup.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_s_tvalid) begin
            r_action <= i_s_tuser;
            r_src    <= i_s_tdata[7:0];
            r_rssi   <= i_s_tdata[15:8];
            r_thr_in <= i_s_tdata[23:16];
            r_dmg_in <= i_s_tdata[39:24];
        end
        if (r_state == ST_MAP) begin
            r_hit <= w_hit;
            r_idx <= w_off[IDX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Table update. A packet accumulates unless the count has saturated;
    // a check clears count and sum but keeps threshold and damage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_count[i] <= '0;
                r_sum[i]   <= '0;
                r_thr[i]   <= '0;
                r_dmg[i]   <= '0;
            end
        end else if ((r_state == ST_EXEC) && r_hit) begin
            if (r_action == ACT_PACKET) begin
                if (!w_sat) begin
                    r_count[r_idx] <= w_cnt + COUNT_W'(1);
                    r_sum[r_idx]   <= w_sum + SUM_W'(r_rssi);
                    r_thr[r_idx]   <= r_thr_in;
                    r_dmg[r_idx]   <= r_dmg_in;
                end
            end else begin
                r_count[r_idx] <= '0;
                r_sum[r_idx]   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_quo  <= w_sum_mag;
            r_rem  <= '0;
            r_div  <= w_cnt;
            r_neg  <= w_sum[SUM_W-1];
            r_dcnt <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo  <= {r_quo[SUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[COUNT_W-1:0] : w_shift[COUNT_W-1:0];
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Result staging.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_res_in_table <= r_hit;
            r_res_near     <= 1'b0;
            r_res_avg      <= '0;
            if (!r_hit) begin
                r_res_dmg <= '0;
            end else if ((r_action == ACT_PACKET) && !w_sat) begin
                r_res_dmg <= r_dmg_in;
            end else begin
                r_res_dmg <= r_dmg[r_idx];
            end
        end else if (r_state == ST_FINISH) begin
            r_res_near <= (w_avg >= w_thr_ext);
            r_res_avg  <= w_avg[RSSI_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_tdata <= {6'b0, r_res_dmg, r_res_avg, r_res_near, r_res_in_table};
        end
    end

    assign o_s_tready  = w_in_ready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: src/psrat_checker.sv
`default_nettype none

module psrat_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while another is in work");

    // A source outside the table reports nothing but zeros.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[31:1] == 31'd0))
        else $error("nonzero result for an unmapped source");

    // Padding stays clear on every result.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:26] == 6'd0))
        else $error("result padding not zero");

endmodule

bind per_source_rssi_average_threshold psrat_checker u_psrat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

FILE: verif/beacon_table_checker.sv
`timescale 1ns / 100ps

module beacon_table_checker
    import psrat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // tdata: source_id[7:0], rssi[15:8], rssi_threshold[23:16], damage_value[39:24]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: action
    input  logic                  i_s_tuser,

    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: in_table[0], near[1], average_rssi[9:2], damage[25:10], zero[31:26]
    input  logic [M_TDATA_W-1:0]  i_m_tdata,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ID_W-1:0]       i_cfg_data,

    output int                    o_mismatch_count,
    output int                    o_pending
);

    typedef struct {
        logic                 in_table;
        logic                 near;
        logic [RSSI_W-1:0]    average_rssi;
        logic [DMG_W-1:0]     damage;
        logic [M_TDATA_W-27:0] pad;
    } beacon_result_t;

    // Private copy of the window registers and of the beacon table.
    logic [ID_W-1:0]    window_first;
    logic [ID_W-1:0]    window_last;
    logic [COUNT_W-1:0] entry_count     [NUM_SOURCES];
    logic [SUM_W-1:0]   entry_sum       [NUM_SOURCES];
    logic [RSSI_W-1:0]  entry_threshold [NUM_SOURCES];
    logic [DMG_W-1:0]   entry_damage    [NUM_SOURCES];

    beacon_result_t pending_beacon_results[$];

    // Applies one request to the table copy and returns the result it must produce.
    function automatic beacon_result_t predict_beacon_result(
        input logic              action,
        input logic [ID_W-1:0]   id,
        input logic [RSSI_W-1:0] rssi,
        input logic [RSSI_W-1:0] threshold,
        input logic [DMG_W-1:0]  damage_in
    );
        beacon_result_t res;
        int slot;
        int sum_now;
        int count_now;
        int mean;
        res.in_table     = 1'b0;
        res.near         = 1'b0;
        res.average_rssi = '0;
        res.damage       = '0;
        res.pad          = '0;
        if (id < window_first || id > window_last) begin
            return res;
        end
        slot = int'(id) - int'(window_first);
        if (slot >= NUM_SOURCES) begin
            return res;
        end
        res.in_table = 1'b1;
        if (action == ACT_PACKET) begin
            // A saturated entry drops the whole packet, threshold and damage included.
            if (entry_count[slot] != COUNT_MAX) begin
                entry_count[slot]     = entry_count[slot] + 1'b1;
                sum_now               = int'($signed(entry_sum[slot])) + int'($signed(rssi));
                entry_sum[slot]       = SUM_W'(sum_now);
                entry_threshold[slot] = threshold;
                entry_damage[slot]    = damage_in;
            end
        end else begin
            if (entry_count[slot] >= MIN_PACKETS) begin
                sum_now          = int'($signed(entry_sum[slot]));
                count_now        = int'(entry_count[slot]);
                mean             = sum_now / count_now;
                res.average_rssi = mean[RSSI_W-1:0];
                res.near         = (mean >= int'($signed(entry_threshold[slot])));
            end
            entry_count[slot] = '0;
            entry_sum[slot]   = '0;
        end
        res.damage = entry_damage[slot];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        beacon_result_t expected;
        beacon_result_t observed;
        if (!i_rst_n) begin
            window_first = '0;
            window_last  = ID_W'(15);
            for (int e = 0; e < NUM_SOURCES; e++) begin
                entry_count[e]     = '0;
                entry_sum[e]       = '0;
                entry_threshold[e] = '0;
                entry_damage[e]    = '0;
            end
            pending_beacon_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIRST_SOURCE_ID: window_first = i_cfg_data;
                    CFG_LAST_SOURCE_ID:  window_last  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_beacon_results.push_back(predict_beacon_result(
                    i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16],
                    i_s_tdata[39:24]));
            end
            if (i_m_tvalid && i_m_tready) begin
                observed.in_table     = i_m_tdata[0];
                observed.near         = i_m_tdata[1];
                observed.average_rssi = i_m_tdata[9:2];
                observed.damage       = i_m_tdata[25:10];
                observed.pad          = i_m_tdata[M_TDATA_W-1:26];
                if (pending_beacon_results.size() == 0) begin
                    if (o_mismatch_count < 10) begin
                        $display("%0t: result with no request outstanding: tdata=%h",
                                 $realtime, i_m_tdata);
                    end
                    o_mismatch_count++;
                end else begin
                    expected = pending_beacon_results.pop_front();
                    if (observed.in_table !== expected.in_table ||
                        observed.near !== expected.near ||
                        observed.average_rssi !== expected.average_rssi ||
                        observed.damage !== expected.damage ||
                        observed.pad !== expected.pad) begin
                        if (o_mismatch_count < 10) begin
                            $display({"%0t: result differs: expected in_table=%0d near=%0d ",
                                      "avg=%0d damage=%h, got in_table=%0d near=%0d avg=%0d ",
                                      "damage=%h pad=%h"}, $realtime,
                                     expected.in_table, expected.near,
                                     $signed(expected.average_rssi), expected.damage,
                                     observed.in_table, observed.near,
                                     $signed(observed.average_rssi), observed.damage,
                                     observed.pad);
                        end
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_pending = pending_beacon_results.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import psrat_pkg::*;

    // Quiet time after the last result, long enough for the slowest request (a check with a
    // full divide) and anything else still inside the block.
    localparam int DRAIN_CYCLES    = 40;
    // Length of the one long receiver stall that backs the block up into its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // About 580 requests, each a full divide behind the longest idle bursts on both sides,
    // plus the long stall and the drains, finish well within this limit.
    localparam int RUN_LIMIT_NS    = 2_000_000;
    localparam int PHASE_ITEMS     = 90;

    logic                  clk;
    logic                  rst_n;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;

    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [ID_W-1:0]       cfg_data;

    int                    mismatch_count;
    int                    results_pending;

    // Idle controls for the request driver and the result receiver.
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    hold_off_request;

    // Window currently programmed, so that well-formed bursts target real table entries.
    int                    cur_first;
    int                    cur_last;

    per_source_rssi_average_threshold u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    beacon_table_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (results_pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs or loses a result.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Result receiver. It stalls in short random bursts while idling is enabled, and
    // once on request it holds off for a long stretch so the block fills and stops
    // taking requests. Every branch waits at least one falling edge, so tready gets
    // a single update per time step.
    initial begin : result_receiver
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
        end
    end

    function automatic int clamp_rssi(input int value);
        if (value > 127) begin
            return 127;
        end
        if (value < -128) begin
            return -128;
        end
        return value;
    endfunction

    // Offers one request and returns at the rising edge where it is taken. Valid stays
    // high afterwards, so back-to-back requests run without a bubble; a gap lowers it
    // first and raises it again at a later falling edge.
    task automatic send_request(
        input logic            action,
        input logic [ID_W-1:0] id,
        input int              rssi,
        input int              threshold,
        input logic [DMG_W-1:0] damage
    );
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {damage, 8'(threshold), 8'(rssi), id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_packets(
        input logic [ID_W-1:0]  id,
        input int               count,
        input int               rssi,
        input int               threshold,
        input logic [DMG_W-1:0] damage
    );
        repeat (count) send_request(ACT_PACKET, id, rssi, threshold, damage);
    endtask

    // A check ignores the packet fields, so they carry random noise.
    task automatic send_check(input logic [ID_W-1:0] id);
        send_request(ACT_CHECK, id, $urandom_range(0, 255), $urandom_range(0, 255),
                     DMG_W'($urandom_range(0, 65535)));
    endtask

    // Drops valid, waits for every outstanding result and then lets the block settle.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0] index,
        input logic [ID_W-1:0]      value
    );
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The window is only reprogrammed once the block has gone quiet.
    task automatic set_window(input int first, input int last);
        drain_results();
        write_register(CFG_FIRST_SOURCE_ID, ID_W'(first));
        write_register(CFG_LAST_SOURCE_ID, ID_W'(last));
        cur_first = first;
        cur_last  = last;
    endtask

    // Most traffic is a burst of packets to one mapped source followed by a check of it,
    // so averages with three or more packets and threshold hits and misses come up often.
    // Strengths cluster around a base and thresholds sit near it, with some bursts fully
    // random. The rest is noise: any source, any action, any field values.
    task automatic run_random_phase(input int n_items);
        int               done;
        int               lo;
        int               hi;
        int               burst;
        int               base;
        int               threshold;
        int               strength;
        bit               spread;
        logic [ID_W-1:0]  id;
        done = 0;
        while (done < n_items) begin
            lo = cur_first;
            hi = (cur_last < cur_first + NUM_SOURCES - 1) ? cur_last
                                                          : cur_first + NUM_SOURCES - 1;
            if (lo <= hi && $urandom_range(0, 4) != 0) begin
                id     = ID_W'($urandom_range(lo, hi));
                burst  = $urandom_range(0, 7);
                base   = int'($urandom_range(0, 255)) - 128;
                spread = ($urandom_range(0, 3) == 0);
                for (int j = 0; j < burst; j++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        threshold = int'($urandom_range(0, 255)) - 128;
                    end else begin
                        threshold = clamp_rssi(base + int'($urandom_range(0, 6)) - 3);
                    end
                    if (spread) begin
                        strength = int'($urandom_range(0, 255)) - 128;
                    end else begin
                        strength = clamp_rssi(base + int'($urandom_range(0, 8)) - 4);
                    end
                    send_request(ACT_PACKET, id, strength, threshold,
                                 DMG_W'($urandom_range(0, 65535)));
                end
                send_check(id);
                done += burst + 1;
            end else begin
                send_request($urandom_range(0, 1) ? ACT_CHECK : ACT_PACKET,
                             ID_W'($urandom_range(0, 255)),
                             int'($urandom_range(0, 255)) - 128,
                             int'($urandom_range(0, 255)) - 128,
                             DMG_W'($urandom_range(0, 65535)));
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int first;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tuser          = ACT_PACKET;
        s_tdata          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_FIRST_SOURCE_ID;
        cfg_data         = '0;
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        hold_off_request = 1'b0;
        cur_first        = 0;
        cur_last         = 15;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first on the reset window of sources 0 to 15.
        // A check of an entry that never saw a packet.
        send_check(3);
        // Strongest packets against the highest threshold: the average just reaches it.
        send_packets(0, 3, 127, 127, 16'hFFFF);
        send_check(0);
        // The previous check cleared the count; the damage value survives.
        send_check(0);
        // Only two packets: no average, no hit, but the entry is still cleared.
        send_packets(15, 2, -128, -128, 16'h0000);
        send_check(15);
        // Weakest strength against the highest threshold: a miss.
        send_packets(15, 3, -128, 127, 16'h8001);
        send_check(15);
        // A sum of -2 over three packets truncates toward zero, which meets threshold 0.
        send_packets(5, 2, -1, 0, 16'h0001);
        send_request(ACT_PACKET, 5, 0, 0, 16'h0001);
        send_check(5);
        // Sources above the window.
        send_request(ACT_PACKET, 16, 50, 0, 16'h1234);
        send_check(16);
        send_request(ACT_PACKET, 255, -50, 0, 16'h4321);

        // Window at the top of the id range; 239 falls just below it.
        set_window(240, 255);
        send_request(ACT_PACKET, 255, 127, -128, 16'hA5A5);
        send_request(ACT_PACKET, 239, 127, -128, 16'h5A5A);
        send_check(255);

        // An empty window: first above last maps nothing.
        set_window(10, 5);
        send_request(ACT_PACKET, 7, 10, 0, 16'h00FF);
        send_check(7);

        // The whole id range is in the window but only sixteen ids fit the table.
        set_window(0, 255);
        send_request(ACT_PACKET, 16, 10, 0, 16'hFF00);
        send_check(16);
        send_request(ACT_PACKET, 0, -7, 3, 16'h0F0F);

        // Random part with idling on both sides. The first phase also carries the long
        // receiver stall while requests keep coming.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_window(0, 15);
        hold_off_request = 1'b1;
        run_random_phase(PHASE_ITEMS);
        set_window(0, 255);
        run_random_phase(PHASE_ITEMS);
        set_window(250, 255);
        run_random_phase(PHASE_ITEMS);
        set_window(128, 143);
        run_random_phase(PHASE_ITEMS);
        first = $urandom_range(0, 255);
        set_window(first, $urandom_range(first, 255));
        run_random_phase(PHASE_ITEMS);

        // Final stretch at full rate with no idling on either side.
        set_window(0, 15);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_phase(PHASE_ITEMS);

        drain_results();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
